// ===== hw/rtl/msc_pkg.sv =====
package msc_pkg;

  // Input item modes.
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_STEP = 1'b1;

  // Configuration register indexes.
  localparam logic [2:0] REG_MASSES  = 3'd0;
  localparam logic [2:0] REG_SPRING  = 3'd1;
  localparam logic [2:0] REG_REST    = 3'd2;
  localparam logic [2:0] REG_DT      = 3'd3;
  localparam logic [2:0] REG_DT_MASS = 3'd4;

  // Configuration reset values.
  localparam logic [5:0]  RST_MASSES  = 6'd10;
  localparam logic [30:0] RST_SPRING  = 31'd65536;
  localparam logic [30:0] RST_REST    = 31'd65536;
  localparam logic [30:0] RST_DT      = 31'd655;
  localparam logic [30:0] RST_DT_MASS = 31'd655;

  // Operations of the shared arithmetic unit.
  typedef enum logic [3:0] {
    OP_MULQ   = 4'b0001,
    OP_MULRAW = 4'b0010,
    OP_SQRT   = 4'b0100,
    OP_DIV    = 4'b1000
  } alu_op_t;

  // Request to the arithmetic unit.
  typedef struct packed {
    alu_op_t            op;
    logic signed [33:0] a;
    logic signed [32:0] b;
    logic [63:0]        wide;
  } alu_cmd_t;

  // Response from the arithmetic unit.
  typedef struct packed {
    logic               done;
    logic signed [63:0] res;
  } alu_rsp_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
    if (v > 65'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -65'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

// ===== hw/rtl/msc_alu.sv =====
module msc_alu import msc_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  alu_cmd_t cmd,
  output alu_rsp_t rsp
);

  localparam int QW = FRAC_BITS + 1;

  typedef enum logic [4:0] {
    A_IDLE = 5'b00001,
    A_MUL1 = 5'b00010,
    A_MUL2 = 5'b00100,
    A_SQRT = 5'b01000,
    A_DIV  = 5'b10000
  } astate_t;

  astate_t            astate;
  logic [5:0]         cnt;
  logic               done;
  logic signed [63:0] res;
  alu_op_t            op_q;
  logic [33:0]        a_m;
  logic [32:0]        b_m;
  logic               neg;
  logic [66:0]        prod;
  logic [63:0]        sv;
  logic [35:0]        rem;
  logic [31:0]        root;
  logic [QW-1:0]      quo;

  logic [33:0] a_mag;
  logic [32:0] b_mag;
  logic [66:0] rnd;
  logic [63:0] mul_mag;
  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic        sq_ge;
  logic [31:0] root_nx;
  logic        dv_ge;
  logic [33:0] rem_dv;
  logic [QW-1:0] quo_nx;
  logic [63:0] qext;

  // Operand magnitudes.
  assign a_mag = cmd.a[33] ? (~cmd.a + 34'd1) : cmd.a;
  assign b_mag = cmd.b[32] ? (~cmd.b + 33'd1) : cmd.b;

  // Product rounding, ties away from zero on the magnitude.
  assign rnd     = (prod + (67'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
  assign mul_mag = (op_q == OP_MULQ) ? rnd[63:0] : prod[63:0];

  // One digit of the square root per cycle.
  assign rem_sh  = {rem[33:0], sv[63:62]};
  assign trial   = {2'b00, root, 2'b01};
  assign sq_ge   = rem_sh >= trial;
  assign root_nx = {root[30:0], sq_ge};

  // One quotient bit of the division per cycle.
  assign dv_ge  = rem[33:0] >= {1'b0, b_m};
  assign rem_dv = dv_ge ? (rem[33:0] - {1'b0, b_m}) : rem[33:0];
  assign quo_nx = {quo[QW-2:0], dv_ge};
  assign qext   = {{(64 - QW){1'b0}}, quo_nx};

  assign rsp = '{done: done, res: res};

  // Sequencing of the unit and its datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      astate <= A_IDLE;
      cnt    <= '0;
      done   <= 1'b0;
    end else begin
      unique case (astate)
        A_IDLE: begin
          done <= 1'b0;
          if (start) begin
            op_q <= cmd.op;
            a_m  <= a_mag;
            b_m  <= b_mag;
            // A quotient takes the sign of the dividend alone.
            neg  <= (cmd.op == OP_DIV) ? cmd.a[33] : (cmd.a[33] ^ cmd.b[32]);
            sv   <= cmd.wide;
            rem  <= (cmd.op == OP_DIV) ? {2'b00, a_mag} : 36'd0;
            root <= '0;
            quo  <= '0;
            cnt  <= '0;
            unique case (cmd.op)
              OP_MULQ, OP_MULRAW: astate <= A_MUL1;
              OP_SQRT: astate <= A_SQRT;
              OP_DIV: astate <= A_DIV;
              default: astate <= A_IDLE;
            endcase
          end
        end
        A_MUL1: begin
          done   <= 1'b0;
          prod   <= 67'(a_m) * 67'(b_m);
          astate <= A_MUL2;
        end
        A_MUL2: begin
          res    <= neg ? -$signed(mul_mag) : $signed(mul_mag);
          done   <= 1'b1;
          astate <= A_IDLE;
        end
        A_SQRT: begin
          rem  <= sq_ge ? (rem_sh - trial) : rem_sh;
          root <= root_nx;
          sv   <= {sv[61:0], 2'b00};
          cnt  <= cnt + 6'd1;
          done <= (cnt == 6'd31);
          if (cnt == 6'd31) begin
            res    <= $signed({32'd0, root_nx});
            astate <= A_IDLE;
          end
        end
        A_DIV: begin
          rem  <= {1'b0, rem_dv, 1'b0};
          quo  <= quo_nx;
          cnt  <= cnt + 6'd1;
          done <= (cnt == 6'(QW - 1));
          if (cnt == 6'(QW - 1)) begin
            res    <= neg ? -$signed(qext) : $signed(qext);
            astate <= A_IDLE;
          end
        end
        default: begin
          done   <= 1'b0;
          astate <= A_IDLE;
        end
      endcase
    end
  end

  // A result is only flagged as the unit goes back to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> astate == A_IDLE) else $error("result flagged while unit busy");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    (astate == A_IDLE && start && (cmd.op == OP_SQRT)) |=> astate == A_SQRT)
    else $error("square root did not start");
  a_sqrt_len: assert property (@(posedge clk) disable iff (rst)
    (astate == A_SQRT) |-> cnt <= 6'd31) else $error("square root overran");

endmodule

// ===== hw/rtl/mass_spring_chain_step.sv =====
// Load item: written in the cycle it is accepted; the block stays ready.
// Step item: worked through on the shared unit, per mass two springs, each a square root
// of 32 steps and, unless its length is zero, two divisions of FRAC_BITS+1 steps.
// Results follow in index order, one per mass, each held until taken.
// Reset: configuration takes its defaults and all velocities read as zero;
// positions are undefined until loaded.
module mass_spring_chain_step import msc_pkg::*; #(
  parameter int MAX_MASSES = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               mode,
  input  logic [4:0]         mass_index,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [4:0]         out_index,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_vx,
  output logic signed [31:0] out_vy,
  output logic               last_mass
);

  localparam int AW = (MAX_MASSES > 1) ? $clog2(MAX_MASSES) : 1;

  typedef enum logic [26:0] {
    S_IDLE    = 27'd1 << 0,
    S_P1_RD   = 27'd1 << 1,
    S_P1_MX   = 27'd1 << 2,
    S_P1_MY   = 27'd1 << 3,
    S_P1_WR   = 27'd1 << 4,
    S_P2_INIT = 27'd1 << 5,
    S_P2_RL   = 27'd1 << 6,
    S_P2_RC   = 27'd1 << 7,
    S_P2_RR   = 27'd1 << 8,
    S_P2_RCAP = 27'd1 << 9,
    S_SP_SQX  = 27'd1 << 10,
    S_SP_SQY  = 27'd1 << 11,
    S_SP_SQRT = 27'd1 << 12,
    S_SP_TEN  = 27'd1 << 13,
    S_SP_RX   = 27'd1 << 14,
    S_SP_RY   = 27'd1 << 15,
    S_SP_FX   = 27'd1 << 16,
    S_SP_FY   = 27'd1 << 17,
    S_SP_ACC  = 27'd1 << 18,
    S_SP_NEXT = 27'd1 << 19,
    S_V_X     = 27'd1 << 20,
    S_V_Y     = 27'd1 << 21,
    S_V_WR    = 27'd1 << 22,
    S_O_RD    = 27'd1 << 23,
    S_O_CAP   = 27'd1 << 24,
    S_O_WT    = 27'd1 << 25,
    S_WAIT    = 27'd1 << 26
  } state_t;

  // Configuration registers.
  logic [5:0]  masses_in_use;
  logic [30:0] stiffness;
  logic [30:0] rest_length;
  logic [30:0] dt_step;
  logic [30:0] step_over_mass;

  // Sequencer state.
  state_t     state;
  state_t     ret;
  logic [5:0] i;
  logic [5:0] n;
  logic       sd;

  // Working registers.
  logic signed [31:0] cx, cy, cvx, cvy;
  logic signed [31:0] lx, ly, nx, ny, rx;
  logic signed [31:0] dx, dy, ten, rtx, rty;
  logic [31:0]        len;
  logic signed [63:0] acc, fsx, fsy;

  // State memories.
  logic signed [31:0]    mem_px [MAX_MASSES];
  logic signed [31:0]    mem_py [MAX_MASSES];
  logic signed [31:0]    mem_vx [MAX_MASSES];
  logic signed [31:0]    mem_vy [MAX_MASSES];
  logic [MAX_MASSES-1:0] vel_ok;
  logic signed [31:0]    px_q, py_q, vx_raw, vy_raw;
  logic                  ok_q;
  logic signed [31:0]    vx_q, vy_q;

  // Combinational controls.
  logic               accept;
  logic               idx_ok;
  logic               is_last;
  logic [5:0]         n_eff;
  logic [AW-1:0]      rd_addr;
  logic               pos_we;
  logic [AW-1:0]      pos_wa;
  logic signed [31:0] pos_wx, pos_wy;
  logic               vel_we;
  logic signed [31:0] vel_wy;
  logic signed [31:0] dxw, dyw;
  logic               alu_start;
  alu_cmd_t           alu_cmd;
  alu_rsp_t           alu_rsp;
  logic signed [63:0] alu_res;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign idx_ok   = {4'b0000, mass_index} < 9'(MAX_MASSES);
  assign is_last  = (i == n - 6'd1);
  assign alu_res  = alu_rsp.res;
  assign vx_q     = ok_q ? vx_raw : 32'sd0;
  assign vy_q     = ok_q ? vy_raw : 32'sd0;
  assign vel_wy   = sat32(65'(cvy) + 65'(alu_res));
  assign dxw      = sat32(65'(cx) - 65'(sd ? nx : lx));
  assign dyw      = sat32(65'(cy) - 65'(sd ? ny : ly));

  // Mass count in use, clipped to the storage depth.
  always_comb begin
    if ({3'b000, masses_in_use} > 9'(MAX_MASSES)) begin
      n_eff = 6'(MAX_MASSES);
    end else begin
      n_eff = masses_in_use;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      masses_in_use  <= RST_MASSES;
      stiffness      <= RST_SPRING;
      rest_length    <= RST_REST;
      dt_step        <= RST_DT;
      step_over_mass <= RST_DT_MASS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MASSES:  masses_in_use  <= cfg_data[5:0];
        REG_SPRING:  stiffness      <= cfg_data;
        REG_REST:    rest_length    <= cfg_data;
        REG_DT:      dt_step        <= cfg_data;
        REG_DT_MASS: step_over_mass <= cfg_data;
        default: ;
      endcase
    end
  end

  // Memory addresses, write ports and arithmetic requests.
  always_comb begin
    rd_addr   = AW'(i);
    pos_we    = 1'b0;
    pos_wa    = AW'(i);
    pos_wx    = cx;
    pos_wy    = sat32(65'(cy) + 65'(alu_res));
    vel_we    = 1'b0;
    alu_start = 1'b0;
    alu_cmd   = '{op: OP_MULQ, a: '0, b: '0, wide: '0};
    unique case (state)
      S_IDLE: begin
        if (accept && mode == MODE_LOAD && idx_ok) begin
          pos_we = 1'b1;
          pos_wa = AW'(mass_index);
          pos_wx = pos_x;
          pos_wy = pos_y;
        end
      end
      S_P1_MX: begin
        alu_start = 1'b1;
        alu_cmd   = '{op: OP_MULQ, a: 34'(vx_q), b: $signed({2'b00, dt_step}), wide: '0};
      end
      S_P1_MY: begin
        alu_start = 1'b1;
        alu_cmd   = '{op: OP_MULQ, a: 34'(cvy), b: $signed({2'b00, dt_step}), wide: '0};
      end
      S_P1_WR: begin
        pos_we = 1'b1;
        if (is_last) begin
          alu_start = 1'b1;
          alu_cmd   = '{op: OP_MULRAW, a: $signed(34'(n) + 34'd1),
                        b: $signed({2'b00, rest_length}), wide: '0};
        end
      end
      S_P2_RL: rd_addr = AW'(i - 6'd1);
      S_P2_RR: rd_addr = AW'(i + 6'd1);
      S_SP_SQX: begin
        alu_start = 1'b1;
        alu_cmd   = '{op: OP_MULRAW, a: 34'(dxw), b: 33'(dxw), wide: '0};
      end
      S_SP_SQY: begin
        alu_start = 1'b1;
        alu_cmd   = '{op: OP_MULRAW, a: 34'(dy), b: 33'(dy), wide: '0};
      end
      S_SP_SQRT: begin
        alu_start = 1'b1;
        alu_cmd   = '{op: OP_SQRT, a: '0, b: '0, wide: acc + alu_res};
      end
      S_SP_TEN: begin
        if (alu_res[31:0] != 32'd0) begin
          alu_start = 1'b1;
          alu_cmd   = '{op: OP_MULQ,
                        a: $signed({2'b00, alu_res[31:0]}) - $signed({3'b000, rest_length}),
                        b: $signed({2'b00, stiffness}), wide: '0};
        end
      end
      S_SP_RX: begin
        alu_start = 1'b1;
        alu_cmd   = '{op: OP_DIV, a: 34'(dx), b: $signed({1'b0, len}), wide: '0};
      end
      S_SP_RY: begin
        alu_start = 1'b1;
        alu_cmd   = '{op: OP_DIV, a: 34'(dy), b: $signed({1'b0, len}), wide: '0};
      end
      S_SP_FX: begin
        alu_start = 1'b1;
        alu_cmd   = '{op: OP_MULQ, a: 34'(ten), b: 33'(rtx), wide: '0};
      end
      S_SP_FY: begin
        alu_start = 1'b1;
        alu_cmd   = '{op: OP_MULQ, a: 34'(ten), b: 33'(rty), wide: '0};
      end
      S_V_X: begin
        alu_start = 1'b1;
        alu_cmd   = '{op: OP_MULQ, a: 34'(sat32(65'(fsx))),
                      b: $signed({2'b00, step_over_mass}), wide: '0};
      end
      S_V_Y: begin
        alu_start = 1'b1;
        alu_cmd   = '{op: OP_MULQ, a: 34'(sat32(65'(fsy))),
                      b: $signed({2'b00, step_over_mass}), wide: '0};
      end
      S_V_WR: vel_we = 1'b1;
      default: ;
    endcase
  end

  // Position and velocity memories with registered reads.
  always_ff @(posedge clk) begin
    if (pos_we) begin
      mem_px[pos_wa] <= pos_wx;
      mem_py[pos_wa] <= pos_wy;
    end
    if (vel_we) begin
      mem_vx[AW'(i)] <= cvx;
      mem_vy[AW'(i)] <= vel_wy;
    end
    px_q   <= mem_px[rd_addr];
    py_q   <= mem_py[rd_addr];
    vx_raw <= mem_vx[rd_addr];
    vy_raw <= mem_vy[rd_addr];
    ok_q   <= vel_ok[rd_addr];
  end

  // A velocity entry reads as zero until a step writes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      vel_ok <= '0;
    end else if (vel_we) begin
      vel_ok[AW'(i)] <= 1'b1;
    end else if (pos_we && state == S_IDLE) begin
      vel_ok[AW'(mass_index)] <= 1'b0;
    end
  end

  // Step sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret       <= S_IDLE;
      i         <= '0;
      n         <= '0;
      sd        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && mode == MODE_STEP && n_eff != 6'd0) begin
            n     <= n_eff;
            i     <= '0;
            state <= S_P1_RD;
          end
        end
        S_P1_RD: state <= S_P1_MX;
        S_P1_MX: begin
          cx    <= px_q;
          cy    <= py_q;
          cvy   <= vy_q;
          ret   <= S_P1_MY;
          state <= S_WAIT;
        end
        S_P1_MY: begin
          cx    <= sat32(65'(cx) + 65'(alu_res));
          ret   <= S_P1_WR;
          state <= S_WAIT;
        end
        S_P1_WR: begin
          if (is_last) begin
            ret   <= S_P2_INIT;
            state <= S_WAIT;
          end else begin
            i     <= i + 6'd1;
            state <= S_P1_RD;
          end
        end
        S_P2_INIT: begin
          rx    <= sat32(65'(alu_res));
          i     <= '0;
          state <= S_P2_RL;
        end
        S_P2_RL: state <= S_P2_RC;
        S_P2_RC: begin
          lx    <= (i == 6'd0) ? 32'sd0 : px_q;
          ly    <= (i == 6'd0) ? 32'sd0 : py_q;
          state <= S_P2_RR;
        end
        S_P2_RR: begin
          cx    <= px_q;
          cy    <= py_q;
          cvx   <= vx_q;
          cvy   <= vy_q;
          state <= S_P2_RCAP;
        end
        S_P2_RCAP: begin
          nx    <= is_last ? rx : px_q;
          ny    <= is_last ? 32'sd0 : py_q;
          fsx   <= '0;
          fsy   <= '0;
          sd    <= 1'b0;
          state <= S_SP_SQX;
        end
        S_SP_SQX: begin
          dx    <= dxw;
          dy    <= dyw;
          ret   <= S_SP_SQY;
          state <= S_WAIT;
        end
        S_SP_SQY: begin
          acc   <= alu_res;
          ret   <= S_SP_SQRT;
          state <= S_WAIT;
        end
        S_SP_SQRT: begin
          ret   <= S_SP_TEN;
          state <= S_WAIT;
        end
        S_SP_TEN: begin
          len <= alu_res[31:0];
          // A spring of zero length pulls with no force.
          if (alu_res[31:0] == 32'd0) begin
            state <= S_SP_NEXT;
          end else begin
            ret   <= S_SP_RX;
            state <= S_WAIT;
          end
        end
        S_SP_RX: begin
          ten   <= sat32(65'(alu_res));
          ret   <= S_SP_RY;
          state <= S_WAIT;
        end
        S_SP_RY: begin
          rtx   <= alu_res[31:0];
          ret   <= S_SP_FX;
          state <= S_WAIT;
        end
        S_SP_FX: begin
          rty   <= alu_res[31:0];
          ret   <= S_SP_FY;
          state <= S_WAIT;
        end
        S_SP_FY: begin
          fsx   <= fsx - alu_res;
          ret   <= S_SP_ACC;
          state <= S_WAIT;
        end
        S_SP_ACC: begin
          fsy   <= fsy - alu_res;
          state <= S_SP_NEXT;
        end
        S_SP_NEXT: begin
          if (!sd) begin
            sd    <= 1'b1;
            state <= S_SP_SQX;
          end else begin
            state <= S_V_X;
          end
        end
        S_V_X: begin
          ret   <= S_V_Y;
          state <= S_WAIT;
        end
        S_V_Y: begin
          cvx   <= sat32(65'(cvx) + 65'(alu_res));
          ret   <= S_V_WR;
          state <= S_WAIT;
        end
        S_V_WR: begin
          if (is_last) begin
            i     <= '0;
            state <= S_O_RD;
          end else begin
            i     <= i + 6'd1;
            state <= S_P2_RL;
          end
        end
        S_O_RD: state <= S_O_CAP;
        S_O_CAP: begin
          out_index <= 5'(i);
          out_x     <= px_q;
          out_y     <= py_q;
          out_vx    <= vx_q;
          out_vy    <= vy_q;
          last_mass <= is_last;
          out_valid <= 1'b1;
          state     <= S_O_WT;
        end
        S_O_WT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (is_last) begin
              state <= S_IDLE;
            end else begin
              i     <= i + 6'd1;
              state <= S_O_RD;
            end
          end
        end
        S_WAIT: begin
          if (alu_rsp.done) begin
            state <= ret;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  msc_alu #(
    .FRAC_BITS(FRAC_BITS)
  ) u_alu (
    .clk  (clk),
    .rst  (rst),
    .start(alu_start),
    .cmd  (alu_cmd),
    .rsp  (alu_rsp)
  );

  // A result is only offered while the sequencer waits on the output.
  a_out_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_O_WT) else $error("result offered outside output wait");
  // The arithmetic unit only reports back to a waiting sequencer.
  a_done_wait: assert property (@(posedge clk) disable iff (rst)
    alu_rsp.done |-> state == S_WAIT) else $error("unit result not awaited");
  // A step with masses in use takes the block out of idle.
  a_step_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && mode == MODE_STEP && n_eff != 6'd0) |=> !in_ready)
    else $error("step item did not start");
  // The mass counter stays inside the chain while a step runs.
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (i < n)) else $error("mass counter out of range");

endmodule

// ===== verif/mass_spring_chain_step_tb.sv =====
module mass_spring_chain_step_tb;
  import msc_pkg::*;

  localparam int CHAIN_LEN = 32;
  localparam int FRAC = 16;
  localparam int CYCLE_LIMIT = 20000000;

  // One emitted mass state.
  typedef struct {
    logic [4:0]         idx;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic               last;
  } mass_state_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = REG_MASSES;
  logic [30:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               mode = MODE_LOAD;
  logic [4:0]         mass_index = '0;
  logic signed [31:0] pos_x = '0;
  logic signed [31:0] pos_y = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [4:0]         out_index;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_vx;
  logic signed [31:0] out_vy;
  logic               last_mass;

  mass_spring_chain_step u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .mass_index(mass_index), .pos_x(pos_x), .pos_y(pos_y),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_index(out_index), .out_x(out_x), .out_y(out_y),
    .out_vx(out_vx), .out_vy(out_vy), .last_mass(last_mass)
  );

  // Shadow copy of the chain and its settings.
  longint chain_x [CHAIN_LEN];
  longint chain_y [CHAIN_LEN];
  longint chain_vx[CHAIN_LEN];
  longint chain_vy[CHAIN_LEN];
  longint unsigned cur_masses, cur_k, cur_rest, cur_dt, cur_dt_mass;

  mass_state_t pending_states[$];
  int errors = 0;
  int states_checked = 0;
  int loads_sent = 0;
  int steps_sent = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off_cycles = 0;
  int cycle_count = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d mass states outstanding", $time,
               pending_states.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      out_ready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each accepted result with the oldest predicted mass state.
  always @(posedge clk) begin
    mass_state_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_states.size() == 0) begin
        errors++;
        $display("%0t: unexpected result index %0d", $time, out_index);
      end else begin
        want = pending_states.pop_front();
        states_checked++;
        if (out_index !== want.idx) begin
          errors++;
          $display("%0t: out_index expected %0d actual %0d", $time, want.idx, out_index);
        end
        if (out_x !== want.x) begin
          errors++;
          $display("%0t: out_x expected %0d actual %0d", $time, want.x, out_x);
        end
        if (out_y !== want.y) begin
          errors++;
          $display("%0t: out_y expected %0d actual %0d", $time, want.y, out_y);
        end
        if (out_vx !== want.vx) begin
          errors++;
          $display("%0t: out_vx expected %0d actual %0d", $time, want.vx, out_vx);
        end
        if (out_vy !== want.vy) begin
          errors++;
          $display("%0t: out_vy expected %0d actual %0d", $time, want.vy, out_vy);
        end
        if (last_mass !== want.last) begin
          errors++;
          $display("%0t: last_mass expected %0d actual %0d", $time, want.last, last_mass);
        end
      end
    end
  end

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned magnitude(input longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  // Fixed-point product, rounded to nearest with ties away from zero.
  function automatic longint fx_mul(input longint a, input longint b);
    longint unsigned p;
    p = magnitude(a) * magnitude(b);
    p = (p + (64'd1 << (FRAC - 1))) >> FRAC;
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Force of one spring on a mass offset by (dx, dy) from its neighbor.
  task automatic spring_pull(input longint dx_in, input longint dy_in,
                             output longint fx, output longint fy);
    longint dx, dy, ext, tension, rx, ry;
    longint unsigned mx, my, len;
    dx = clamp32(dx_in);
    dy = clamp32(dy_in);
    mx = magnitude(dx);
    my = magnitude(dy);
    len = floor_sqrt(mx * mx + my * my);
    if (len == 0) begin
      fx = 0;
      fy = 0;
    end else begin
      ext = longint'(len) - longint'(cur_rest);
      tension = clamp32(fx_mul(longint'(cur_k), ext));
      rx = longint'((mx << FRAC) / len);
      ry = longint'((my << FRAC) / len);
      if (dx < 0) rx = -rx;
      if (dy < 0) ry = -ry;
      fx = -fx_mul(tension, rx);
      fy = -fx_mul(tension, ry);
    end
  endtask

  // Semi-implicit Euler step of the shadow chain; queues one state per mass.
  task automatic advance_chain();
    int n;
    longint right_x, lx, ly, rxp, ryp, flx, fly, frx, fry;
    mass_state_t s;
    n = int'(cur_masses);
    if (n > CHAIN_LEN) n = CHAIN_LEN;
    for (int i = 0; i < n; i++) begin
      chain_x[i] = clamp32(chain_x[i] + fx_mul(chain_vx[i], longint'(cur_dt)));
      chain_y[i] = clamp32(chain_y[i] + fx_mul(chain_vy[i], longint'(cur_dt)));
    end
    right_x = clamp32(longint'(n + 1) * longint'(cur_rest));
    for (int i = 0; i < n; i++) begin
      lx = (i == 0) ? 0 : chain_x[i-1];
      ly = (i == 0) ? 0 : chain_y[i-1];
      rxp = (i == n - 1) ? right_x : chain_x[i+1];
      ryp = (i == n - 1) ? 0 : chain_y[i+1];
      spring_pull(chain_x[i] - lx, chain_y[i] - ly, flx, fly);
      spring_pull(chain_x[i] - rxp, chain_y[i] - ryp, frx, fry);
      chain_vx[i] = clamp32(chain_vx[i] + fx_mul(clamp32(flx + frx), longint'(cur_dt_mass)));
      chain_vy[i] = clamp32(chain_vy[i] + fx_mul(clamp32(fly + fry), longint'(cur_dt_mass)));
    end
    for (int i = 0; i < n; i++) begin
      s.idx = i[4:0];
      s.x = chain_x[i][31:0];
      s.y = chain_y[i][31:0];
      s.vx = chain_vx[i][31:0];
      s.vy = chain_vy[i][31:0];
      s.last = (i == n - 1);
      pending_states.push_back(s);
    end
  endtask

  // Offer one item after a random gap and wait until it is accepted.
  task automatic send_item(input logic m, input logic [4:0] idx,
                           input logic signed [31:0] x, input logic signed [31:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    mass_index <= idx;
    pos_x <= x;
    pos_y <= y;
    do @(posedge clk); while (!in_ready);
    if (m == MODE_LOAD) begin
      chain_x[idx] = longint'(x);
      chain_y[idx] = longint'(y);
      chain_vx[idx] = 0;
      chain_vy[idx] = 0;
      loads_sent++;
    end else begin
      advance_chain();
      steps_sent++;
    end
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait until the block is idle, then write one register.
  task automatic write_reg(input logic [2:0] idx, input logic [30:0] value);
    in_valid <= 1'b0;
    wait (pending_states.size() == 0);
    repeat (60) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MASSES:  cur_masses = value[5:0];
      REG_SPRING:  cur_k = value;
      REG_REST:    cur_rest = value;
      REG_DT:      cur_dt = value;
      REG_DT_MASS: cur_dt_mass = value;
      default: ;
    endcase
  endtask

  // A mass near its rest spot with some random jitter.
  task automatic load_near_rest(input int i, input int jitter);
    longint home;
    home = longint'(i + 1) * longint'(cur_rest);
    send_item(MODE_LOAD, i[4:0], 32'(clamp32(home + $urandom_range(2 * jitter) - jitter)),
              32'($urandom_range(2 * jitter) - jitter));
  endtask

  // Every mass gets a defined position before any step reads it.
  task automatic test_initial_load();
    for (int i = 0; i < CHAIN_LEN; i++) load_near_rest(i, 20000);
    send_item(MODE_STEP, 5'd0, 32'sd0, 32'sd0);
    send_item(MODE_STEP, 5'd0, 32'sd0, 32'sd0);
  endtask

  // Field extremes, zero-length springs and saturating positions.
  task automatic test_special_cases();
    write_reg(REG_MASSES, 31'd3);
    // Mass on the left anchor and two masses on top of each other.
    send_item(MODE_LOAD, 5'd0, 32'sd0, 32'sd0);
    send_item(MODE_LOAD, 5'd1, 32'sd131072, 32'sd4096);
    send_item(MODE_LOAD, 5'd2, 32'sd131072, 32'sd4096);
    send_item(MODE_STEP, 5'd0, 32'sd0, 32'sd0);
    // Positions at the extremes of the signed range.
    send_item(MODE_LOAD, 5'd0, 32'sh7fffffff, 32'sh80000000);
    send_item(MODE_LOAD, 5'd1, 32'sh80000000, 32'sh7fffffff);
    send_item(MODE_LOAD, 5'd2, 32'sh7fffffff, 32'sh7fffffff);
    send_item(MODE_STEP, 5'd0, 32'sd0, 32'sd0);
    send_item(MODE_STEP, 5'd0, 32'sd0, 32'sd0);
    // Highest index is stored but stays out of a short chain.
    send_item(MODE_LOAD, 5'd31, 32'sh5a5a5a5a, 32'sha5a5a5a5);
    send_item(MODE_STEP, 5'd0, 32'sd0, 32'sd0);
    stop_sending();
  endtask

  // Register extremes, an empty chain and a count above the maximum.
  task automatic test_register_extremes();
    write_reg(REG_SPRING, 31'h7fffffff);
    write_reg(REG_REST, 31'h7fffffff);
    write_reg(REG_DT, 31'h7fffffff);
    write_reg(REG_DT_MASS, 31'h7fffffff);
    write_reg(REG_MASSES, 31'd2);
    send_item(MODE_STEP, 5'd0, 32'sd0, 32'sd0);
    write_reg(REG_SPRING, 31'd0);
    write_reg(REG_REST, 31'd0);
    write_reg(REG_DT, 31'd0);
    write_reg(REG_DT_MASS, 31'd0);
    send_item(MODE_STEP, 5'd0, 32'sd0, 32'sd0);
    write_reg(REG_MASSES, 31'd0);
    send_item(MODE_STEP, 5'd0, 32'sd0, 32'sd0);
    write_reg(REG_SPRING, 31'd65536);
    write_reg(REG_REST, 31'd65536);
    write_reg(REG_DT, 31'd655);
    write_reg(REG_DT_MASS, 31'd655);
    write_reg(REG_MASSES, 31'd63);
    for (int i = 0; i < CHAIN_LEN; i++) load_near_rest(i, 3000);
    send_item(MODE_STEP, 5'd0, 32'sd0, 32'sd0);
    stop_sending();
  endtask

  // Long receiver hold-off while steps keep arriving.
  task automatic test_backpressure();
    write_reg(REG_MASSES, 31'd4);
    hold_off_cycles = 6000;
    for (int i = 0; i < 4; i++) send_item(MODE_STEP, 5'd0, 32'sd0, 32'sd0);
    stop_sending();
  endtask

  // Random settings, then loads, most of them near rest, mixed with steps.
  task automatic test_random_phase(input int snd, input int rcv, input int items);
    int n;
    int r;
    send_idle_pct = snd;
    recv_idle_pct = rcv;
    for (int k = 0; k < items; k++) begin
      if (k % 40 == 0) begin
        n = ($urandom_range(9) == 0) ? 32 : $urandom_range(1, 8);
        write_reg(REG_MASSES, 31'(n));
        write_reg(REG_SPRING, 31'($urandom_range(1 << 14, 1 << 20)));
        write_reg(REG_REST, 31'($urandom_range(1 << 14, 1 << 18)));
        write_reg(REG_DT, 31'($urandom_range(1, 1 << 13)));
        write_reg(REG_DT_MASS, 31'($urandom_range(1, 1 << 13)));
      end
      r = $urandom_range(99);
      if (r < 45) begin
        load_near_rest($urandom_range(CHAIN_LEN - 1), 1 << $urandom_range(4, 18));
      end else if (r < 55) begin
        send_item(MODE_LOAD, 5'($urandom), 32'($urandom), 32'($urandom));
      end else begin
        send_item(MODE_STEP, 5'($urandom), 32'($urandom), 32'($urandom));
      end
    end
    stop_sending();
  endtask

  initial begin
    cur_masses = RST_MASSES;
    cur_k = RST_SPRING;
    cur_rest = RST_REST;
    cur_dt = RST_DT;
    cur_dt_mass = RST_DT_MASS;
    for (int i = 0; i < CHAIN_LEN; i++) begin
      chain_x[i] = 0;
      chain_y[i] = 0;
      chain_vx[i] = 0;
      chain_vy[i] = 0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_initial_load();
    test_special_cases();
    test_register_extremes();
    test_backpressure();
    test_random_phase(37, 54, 50);
    test_random_phase(54, 37, 50);
    test_random_phase(0, 0, 50);

    wait (pending_states.size() == 0);
    repeat (100) @(posedge clk);
    $display("Sent %0d loads and %0d steps; checked %0d mass states.",
             loads_sent, steps_sent, states_checked);
    $display("Covered empty and oversized chains, zero-length springs and saturation.");
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/msc_pkg.sv
hw/rtl/msc_alu.sv
hw/rtl/mass_spring_chain_step.sv
verif/mass_spring_chain_step_tb.sv
